[design/chsq_pkg.sv]
// Package for the chi-square histogram distance block.
// Holds the item types passed between front, queue, back and divider.
// No dependencies.
`timescale 1ns / 1ps

package chsq_pkg;

    localparam int BIN_W   = 32;
    localparam int EPS_W   = 16;
    localparam int DEN_W   = BIN_W + 2;
    localparam int PROD_W  = 2 * BIN_W;
    localparam int SUM_W   = 48;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified bin pair: epsilon cancels in the difference
    typedef struct packed {
        logic [BIN_W-1:0] diff;
        logic [DEN_W-1:0] den;
        logic             last;
    } t_work;

    // Request to the divider
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

endpackage

[design/chsq_front.sv]
// Front end: epsilon register, input acceptance and bin classification.
// Produces |a-b| and a+b+2*epsilon per item. Depends on chsq_pkg.
`timescale 1ns / 1ps

module chsq_front import chsq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [BIN_W-1:0] i_bin_a,
    input  logic [BIN_W-1:0] i_bin_b,
    input  logic             i_last_bin,
    output logic             o_item_valid,
    output t_work            o_item,
    input  logic             i_item_ready
);

    logic [EPS_W-1:0] r_eps;
    logic             r_valid;
    t_work            r_item;
    t_work            n_item;

    // Classification
    always_comb begin
        n_item.diff = (i_bin_a >= i_bin_b) ? (i_bin_a - i_bin_b) : (i_bin_b - i_bin_a);
        n_item.den  = {2'b00, i_bin_a} + {2'b00, i_bin_b}
                    + {{(DEN_W-EPS_W-1){1'b0}}, r_eps, 1'b0};
        n_item.last = i_last_bin;
    end

    assign o_in_ready   = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Output stage toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

[design/chsq_queue.sv]
// Short register queue between front and back.
// Depth from QUEUE_DEPTH in chsq_pkg.
`timescale 1ns / 1ps

module chsq_queue import chsq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_work i_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_work o_item
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_item       = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

[design/chsq_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Quotient is known to fit BIN_W bits (num[63:32] < den). Depends on chsq_pkg.
`timescale 1ns / 1ps

module chsq_div import chsq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [BIN_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(BIN_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [BIN_W-1:0] r_acc;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    // One restoring step: shift in next dividend bit, compare, subtract
    always_comb begin
        trial = {r_rem, r_acc[BIN_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(BIN_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BIN_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: low dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(DEN_W-BIN_W){1'b0}}, i_req.num[PROD_W-1:BIN_W]};
            r_acc <= i_req.num[BIN_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_acc <= {r_acc[BIN_W-2:0], qbit};
        end
    end

endmodule

[design/chsq_back.sv]
// Back end: squares the difference, divides by the sum, accumulates
// with saturation and holds the result item. Depends on chsq_pkg, chsq_div.
`timescale 1ns / 1ps

module chsq_back import chsq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  t_work            i_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [SUM_W-1:0] o_distance,
    output logic             o_saturated
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_ACC
    } t_state;

    t_state            r_state;
    logic [BIN_W-1:0]  r_diff;
    logic [DEN_W-1:0]  r_den;
    logic              r_last;
    logic [PROD_W-1:0] r_prod;
    logic              r_div_start;
    logic [BIN_W-1:0]  r_term;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_distance;
    logic              r_saturated;

    t_div_req          div_req;
    logic              div_done;
    logic [BIN_W-1:0]  div_quot;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  n_sum;
    logic              n_ovf;
    logic              out_free;

    assign div_req.start = r_div_start;
    assign div_req.num   = r_prod;
    assign div_req.den   = r_den;

    chsq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Saturating accumulate
    always_comb begin
        sum_wide = {1'b0, r_sum} + {{(SUM_W-BIN_W+1){1'b0}}, r_term};
        n_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        n_ovf    = r_ovf || sum_wide[SUM_W];
    end

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_item_ready = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_distance   = r_distance;
    assign o_saturated  = r_saturated;

    // Sequencer with accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // divider start pulses right after the multiply step
            r_div_start <= (r_state == S_MUL);
            if ((r_state == S_ACC) && r_last && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_diff  <= i_item.diff;
                        r_den   <= i_item.den;
                        r_last  <= i_item.last;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_diff) * PROD_W'(r_diff);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        // zero denominator means zero term
                        r_term  <= (r_den == '0) ? '0 : div_quot;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!r_last) begin
                        r_sum   <= n_sum;
                        r_ovf   <= n_ovf;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_distance  <= n_sum;
                        r_saturated <= n_ovf;
                        r_sum       <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/chi_square_hist_distance_top.sv]
// Top level of the chi-square histogram distance block.
// Instantiates chsq_front, chsq_queue and chsq_back; uses chsq_pkg.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_ready       i_bin_a, i_bin_b, i_last_bin
//   out       output     o_out_valid / i_out_ready     o_distance, o_saturated
//   cfg       input      i_cfg_we (no wait)            i_cfg_wdata (epsilon)
//
// Each item passes through the back end in order: accept, multiply, divider load,
// 32 radix-2 divider steps, quotient capture and accumulate.
// The front stage and a two-entry queue take items ahead of the back end.
// Synchronous active-low reset clears control state; epsilon resets to 1.
// A result item holds in the output register while i_out_ready is low;
// the back end stalls only when a further last item is ready to emit.
`timescale 1ns / 1ps

module chi_square_hist_distance_top import chsq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [BIN_W-1:0] i_bin_a,
    input  logic [BIN_W-1:0] i_bin_b,
    input  logic             i_last_bin,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [SUM_W-1:0] o_distance,
    output logic             o_saturated
);

    logic  front_valid;
    logic  front_ready;
    t_work front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_work queue_item;

    chsq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bin_a      (i_bin_a),
        .i_bin_b      (i_bin_b),
        .i_last_bin   (i_last_bin),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (front_ready)
    );

    chsq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_item       (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_item       (queue_item)
    );

    chsq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_distance   (o_distance),
        .o_saturated  (o_saturated)
    );

endmodule

[tb/tb_chi_square_hist_distance_top.sv]
// Self-checking testbench for chi_square_hist_distance_top.
// Holds a scoreboard class that predicts the chi-square totals, and the driver tasks.
// Depends on chsq_pkg and the block's RTL only.
`timescale 1ns / 1ps

import chsq_pkg::*;

// One expected total per histogram
typedef struct packed {
    logic [SUM_W-1:0] distance;
    logic             saturated;
} t_hist_total;

// Tracks the running chi-square sum and holds the totals still due
class chi_sum_tracker;
    logic [EPS_W-1:0] eps;
    logic [SUM_W-1:0] acc;
    logic             acc_clipped;
    t_hist_total      totals_due[$];
    int unsigned      errors;

    function new();
        eps         = EPS_RESET;
        acc         = '0;
        acc_clipped = 1'b0;
        errors      = 0;
    endfunction

    function void set_epsilon(logic [EPS_W-1:0] v);
        eps = v;
    endfunction

    function int unsigned due();
        return totals_due.size();
    endfunction

    // floor(d^2 / (x + y)); epsilon cancels in d, so d^2 fits in 64 bits
    function logic [63:0] chi_term(logic [BIN_W-1:0] a, logic [BIN_W-1:0] b);
        logic [32:0] x;
        logic [32:0] y;
        logic [63:0] d;
        logic [63:0] den;
        x   = {1'b0, a} + eps;
        y   = {1'b0, b} + eps;
        d   = (x >= y) ? 64'(x - y) : 64'(y - x);
        den = 64'(x) + 64'(y);
        if (den == 64'd0)
            return 64'd0;
        return (d * d) / den;
    endfunction

    // Accepted bin pair: accumulate with clamp, close the histogram on last
    function void note_bin(logic [BIN_W-1:0] a, logic [BIN_W-1:0] b, logic last);
        logic [63:0] term;
        t_hist_total closed;
        term = chi_term(a, b);
        if (term > 64'(SUM_MAX - acc)) begin
            acc         = SUM_MAX;
            acc_clipped = 1'b1;
        end else begin
            acc = acc + term[SUM_W-1:0];
        end
        if (last) begin
            closed.distance  = acc;
            closed.saturated = acc_clipped;
            totals_due       = {totals_due, closed};
            acc              = '0;
            acc_clipped      = 1'b0;
        end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("chi mismatch: %s got 0x%0h want 0x%0h", what, got, want);
        errors++;
    endtask

    // Accepted result item against the oldest total due
    task check_total(logic [SUM_W-1:0] distance, logic saturated);
        t_hist_total want;
        if (totals_due.size() == 0) begin
            report("result with no total due, distance", 64'(distance), 64'd0);
            return;
        end
        want = totals_due.pop_front();
        if (distance !== want.distance)
            report("distance", 64'(distance), 64'(want.distance));
        if (saturated !== want.saturated)
            report("saturated", 64'(saturated), 64'(want.saturated));
    endtask
endclass

module tb_chi_square_hist_distance_top;

    localparam int QUIET_LIMIT  = 20000;  // cycles with no item moving
    localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
    localparam int SETTLE       = 150;    // back-end latency margin
    localparam int RAND_PER_MODE = 560;
    localparam int MAX_RUN_BINS = 250;    // run of largest terms in one histogram

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [EPS_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [BIN_W-1:0] i_bin_a     = '0;
    logic [BIN_W-1:0] i_bin_b     = '0;
    logic             i_last_bin  = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [SUM_W-1:0] o_distance;
    logic             o_saturated;

    chi_sum_tracker chi_sums = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned bins_sent   = 0;

    chi_square_hist_distance_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_bin_a     (i_bin_a),
        .i_bin_b     (i_bin_b),
        .i_last_bin  (i_last_bin),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_saturated (o_saturated)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor both channels at the rising edge; watchdog on silence
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            chi_sums.note_bin(i_bin_a, i_bin_b, i_last_bin);
        if (i_rst_n && o_out_valid && i_out_ready)
            chi_sums.check_total(o_distance, o_saturated);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_chi_square_hist_distance_top: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One bin pair; valid holds until accepted
    task send_bin(logic [BIN_W-1:0] a, logic [BIN_W-1:0] b, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_bin_a    <= a;
        i_bin_b    <= b;
        i_last_bin <= last;
        do @(posedge i_clk); while (!o_in_ready);
        bins_sent++;
    endtask

    // Drop valid, wait for every total, then let the back end settle
    task wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (chi_sums.due() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_epsilon(logic [EPS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        chi_sums.set_epsilon(v);
    endtask

    function automatic logic [BIN_W-1:0] rand_bin();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return BIN_W'($urandom_range(65535));
            3:       return {16'($urandom_range(255)), 16'h0};
            default: return $urandom;
        endcase
    endfunction

    // Random histogram of len bin pairs; b often equal to a or one bit away from it
    task send_hist(int unsigned len);
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            a = rand_bin();
            case ($urandom_range(3))
                0:       b = a;
                1:       b = a ^ (32'd1 << $urandom_range(31));
                default: b = rand_bin();
            endcase
            send_bin(a, b, i == len - 1);
        end
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 12)
            return $urandom_range(8, 1);
        if (r < 18)
            return $urandom_range(24, 9);
        return $urandom_range(60, 25);
    endfunction

    initial begin
        int unsigned mode_start;
        int unsigned next_cfg;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset epsilon of 1, field extremes
        send_bin('0, '0, 1'b1);
        send_bin('1, '0, 1'b0);
        send_bin('0, '1, 1'b0);
        send_bin('1, '1, 1'b1);
        send_bin(32'd1, '0, 1'b0);
        send_bin(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        wait_drain();

        // Zero epsilon: zero denominator gives a zero term
        write_epsilon('0);
        send_bin('0, '0, 1'b1);
        send_bin('0, '0, 1'b0);
        send_bin(32'd5, '0, 1'b1);
        send_bin('1, '0, 1'b1);
        wait_drain();

        // Largest epsilon
        write_epsilon('1);
        send_bin('1, '0, 1'b0);
        send_bin('0, '1, 1'b1);
        send_bin('0, '0, 1'b1);
        wait_drain();

        // Long run of the largest term builds a wide sum, then a clear check
        write_epsilon('0);
        for (int unsigned i = 0; i < MAX_RUN_BINS; i++)
            send_bin('1, '0, 1'b0);
        send_bin('0, '0, 1'b1);
        send_bin(32'd7, 32'd3, 1'b1);
        wait_drain();

        // Random histograms under three idle patterns
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 77;
                    write_epsilon(EPS_W'($urandom_range(65535)));
                end
                1: begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 30;
                    write_epsilon('1);
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    write_epsilon(EPS_W'($urandom_range(3)));
                end
            endcase
            mode_start = bins_sent;
            next_cfg   = bins_sent + 200;
            while (bins_sent - mode_start < RAND_PER_MODE) begin
                // Receiver holds off while single-bin histograms pile up
                if (mode == 2 && bins_sent - mode_start >= RAND_PER_MODE / 2
                        && next_cfg != 0) begin
                    next_cfg    = 0;
                    rx_hold_req = 1'b1;
                    for (int k = 0; k < 24; k++)
                        send_bin(rand_bin(), rand_bin(), 1'b1);
                end
                if (mode != 2 && bins_sent >= next_cfg) begin
                    next_cfg = bins_sent + 200;
                    wait_drain();
                    write_epsilon(EPS_W'($urandom_range(65535)));
                end
                send_hist(pick_len());
            end
            wait_drain();
        end

        repeat (200) @(posedge i_clk);
        if (chi_sums.errors == 0)
            $display("tb_chi_square_hist_distance_top: done, clean");
        else
            $display("tb_chi_square_hist_distance_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
design/chsq_pkg.sv
design/chsq_front.sv
design/chsq_queue.sv
design/chsq_div.sv
design/chsq_back.sv
design/chi_square_hist_distance_top.sv
tb/tb_chi_square_hist_distance_top.sv
